// ----- rtl/knock_interval_recorder_defines.svh -----
// Assertion macros for the recorder top-level RTL.
`ifndef KNOCK_INTERVAL_RECORDER_DEFINES_SVH
`define KNOCK_INTERVAL_RECORDER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KIR_ASSERT_NOW(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define KIR_ASSERT_NEXT(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

// ----- rtl/kir_pkg.sv -----
package kir_pkg;

    localparam int WINDOW_DEFAULT        = 10;
    localparam int MAX_INTERVALS_DEFAULT = 32;

    localparam int SAMPLE_W   = 12;
    localparam int ELAPSED_W  = 16;
    localparam int INTERVAL_W = 16;
    localparam int INDEX_W    = 5;
    localparam int COUNT_W    = 6;
    localparam int TOTAL_W    = 21;
    localparam int TIMER_W    = 18;
    localparam int GAIN_W     = 4;
    localparam int OFFSET_W   = 12;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_MAX = 4095;

    localparam logic [GAIN_W-1:0]     GAIN_RESET    = 4'd2;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET  = 12'd200;
    localparam logic [ELAPSED_W-1:0]  HOLDOFF_RESET = 16'd200;
    localparam logic [ELAPSED_W-1:0]  END_GAP_RESET = 16'd2000;

    typedef enum logic [1:0] {
        REG_GAIN    = 2'd0,
        REG_OFFSET  = 2'd1,
        REG_HOLDOFF = 2'd2,
        REG_END_GAP = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } smp_word_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_ms;
        logic [INDEX_W-1:0]    interval_index;
        logic [COUNT_W-1:0]    interval_count;
        logic [TOTAL_W-1:0]    total_ms;
        logic                  overflowed;
        logic                  last;
    } ivl_word_t;

    typedef struct packed {
        logic load;
        logic update;
    } win_ctl_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    function automatic int sum_width(input int window);
        return $clog2(window * SAMPLE_MAX + 1);
    endfunction

endpackage

// ----- rtl/knock_interval_recorder.sv -----
// Channel   Direction  Word          Handshake
// smp       in         smp_word_t    smp_valid / smp_stall
// ivl       out        ivl_word_t    ivl_valid / ivl_stall
// cfg       in         cfg_data      cfg_we, cfg_index
//
// Each accepted sample passes through window update, divide start,
// reciprocal multiply and knock decision before the next is accepted.
// A finished pattern then emits one interval at a time, one store read and
// one output beat each, holding each beat while ivl_stall is high.
// Reset is asynchronous; window valid bits stand in for a zeroed window, so
// there is no clearing pass. smp_stall stays high whenever not idle.
module knock_interval_recorder #(
    parameter int WINDOW        = kir_pkg::WINDOW_DEFAULT,
    parameter int MAX_INTERVALS = kir_pkg::MAX_INTERVALS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            smp_valid,
    output logic                            smp_stall,
    input  kir_pkg::smp_word_t              smp_data,
    output logic                            ivl_valid,
    input  logic                            ivl_stall,
    output kir_pkg::ivl_word_t              ivl_data,
    input  logic                            cfg_we,
    input  kir_pkg::cfg_reg_t               cfg_index,
    input  logic [kir_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kir_pkg::*;

    `include "knock_interval_recorder_defines.svh"

    localparam int SUM_W = sum_width(WINDOW);
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int THR_W = GAIN_W + SAMPLE_W + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UPDATE = 7'b0000010,
        S_START  = 7'b0000100,
        S_DIVIDE = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_READ   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    smp_word_t             smp_reg, smp_next;
    logic [GAIN_W-1:0]     gain_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [ELAPSED_W-1:0]  holdoff_reg;
    logic [ELAPSED_W-1:0]  end_gap_reg;
    logic [TIMER_W-1:0]    timer_reg, timer_next;
    logic                  active_reg, active_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  drop_reg, drop_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;

    win_ctl_t              win_ctl;
    store_ctl_t            store_ctl;
    logic [SUM_W-1:0]      win_sum;
    logic                  div_start;
    logic                  div_done;
    logic [SAMPLE_W-1:0]   avg;
    logic [INTERVAL_W-1:0] store_rd;

    logic [TIMER_W:0]      timer_sum;
    logic [TOTAL_W:0]      total_sum;
    logic [THR_W-1:0]      threshold;
    logic                  end_due;
    logic                  knock;
    logic                  emit_last;

    kir_window #(.WINDOW(WINDOW)) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (win_ctl),
        .sample (smp_reg.sample),
        .sum    (win_sum)
    );

    kir_divider #(.WINDOW(WINDOW)) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (win_sum),
        .done     (div_done),
        .quotient (avg)
    );

    kir_store #(.MAX_INTERVALS(MAX_INTERVALS)) u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (timer_reg[INTERVAL_W-1:0]),
        .rd_addr (ptr_reg),
        .rd_data (store_rd)
    );

    assign timer_sum = {1'b0, timer_reg} + (TIMER_W+1)'(smp_reg.elapsed_ms);
    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(timer_reg);
    assign threshold = THR_W'(gain_reg) * THR_W'(avg) + THR_W'(offset_reg);
    assign end_due   = active_reg && (timer_reg > TIMER_W'(end_gap_reg));
    assign knock     = (timer_reg >= TIMER_W'(holdoff_reg))
                    && (THR_W'(smp_reg.sample) >= threshold);
    assign emit_last = (CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next       = state_reg;
        smp_next         = smp_reg;
        timer_next       = timer_reg;
        active_next      = active_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        drop_next        = drop_reg;
        ptr_next         = ptr_reg;
        win_ctl          = '0;
        store_ctl        = '0;
        div_start        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (smp_valid)
                begin
                    smp_next     = smp_data;
                    win_ctl.load = 1'b1;
                    state_next   = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                win_ctl.update = 1'b1;
                timer_next     = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
                state_next     = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                ptr_next   = '0;
                if (end_due)
                begin
                    if (count_reg == '0)
                    begin
                        timer_next  = TIMER_W'(holdoff_reg);
                        active_next = 1'b0;
                        total_next  = '0;
                        drop_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else if (knock)
                begin
                    if (active_reg)
                    begin
                        if (count_reg < CNT_W'(MAX_INTERVALS))
                        begin
                            store_ctl.wr_en = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            total_next      = total_sum[TOTAL_W] ? '1
                                                                 : total_sum[TOTAL_W-1:0];
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    timer_next  = '0;
                    active_next = 1'b1;
                end
            end
            S_READ:
            begin
                store_ctl.rd_en = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ivl_stall)
                begin
                    if (emit_last)
                    begin
                        timer_next  = '0;
                        active_next = 1'b0;
                        count_next  = '0;
                        total_next  = '0;
                        drop_next   = 1'b0;
                        ptr_next    = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gain_reg    <= GAIN_RESET;
            offset_reg  <= OFFSET_RESET;
            holdoff_reg <= HOLDOFF_RESET;
            end_gap_reg <= END_GAP_RESET;
            timer_reg   <= '0;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
            drop_reg    <= 1'b0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            timer_reg  <= timer_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            drop_reg   <= drop_next;
            ptr_reg    <= ptr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN:    gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_OFFSET:  offset_reg  <= cfg_data[OFFSET_W-1:0];
                    REG_HOLDOFF: holdoff_reg <= cfg_data[ELAPSED_W-1:0];
                    REG_END_GAP: end_gap_reg <= cfg_data[ELAPSED_W-1:0];
                    default:     gain_reg    <= gain_reg;
                endcase
            end
        end
    end

    assign smp_stall = (state_reg != S_IDLE);
    assign ivl_valid = (state_reg == S_EMIT);

    assign ivl_data.interval_ms    = store_rd;
    assign ivl_data.interval_index = INDEX_W'(ptr_reg);
    assign ivl_data.interval_count = COUNT_W'(count_reg);
    assign ivl_data.total_ms       = total_reg;
    assign ivl_data.overflowed     = drop_reg;
    assign ivl_data.last           = emit_last;

    `KIR_ASSERT_NOW(a_emit_blocks_input, clk, rst_n, ivl_valid, smp_stall,
        "input accepted while a word is pending")
    `KIR_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_INTERVALS),
        "stored count exceeds capacity")
    `KIR_ASSERT_NOW(a_ptr_in_range, clk, rst_n, ivl_valid, CNT_W'(ptr_reg) < count_reg,
        "emit pointer past stored count")
    `KIR_ASSERT_NEXT(a_emit_clears, clk, rst_n, ivl_valid && !ivl_stall && emit_last,
        (count_reg == '0) && !active_reg && (state_reg == S_IDLE),
        "pattern not cleared after last word")

endmodule

// ----- rtl/kir_window.sv -----
module kir_window #(
    parameter int  WINDOW = kir_pkg::WINDOW_DEFAULT,
    localparam int SUM_W  = kir_pkg::sum_width(WINDOW)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kir_pkg::win_ctl_t             ctl,
    input  logic [kir_pkg::SAMPLE_W-1:0]  sample,
    output logic [SUM_W-1:0]              sum
);
    import kir_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [WINDOW-1:0]   valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    sum_next;
    logic [SLOT_W-1:0]   slot_next;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rd_data_reg <= mem[slot_reg];
        end
        if (ctl.update)
        begin
            mem[slot_reg] <= sample;
        end
    end

    assign old_sample = rd_valid_reg ? rd_data_reg : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample);
    assign slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            slot_reg     <= '0;
            sum_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                rd_valid_reg <= valid_reg[slot_reg];
            end
            if (ctl.update)
            begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
                sum_reg             <= sum_next;
            end
        end
    end

    assign sum = sum_reg;

endmodule

// ----- rtl/kir_divider.sv -----
module kir_divider #(
    parameter int  WINDOW = kir_pkg::WINDOW_DEFAULT,
    localparam int SUM_W  = kir_pkg::sum_width(WINDOW)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              dividend,
    output logic                          done,
    output logic [kir_pkg::SAMPLE_W-1:0]  quotient
);
    import kir_pkg::*;

    // Divide by WINDOW as a multiply by a rounded-up reciprocal, exact for
    // every SUM_W-bit dividend.
    localparam int SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] quo_reg;
    logic                done_reg;

    assign product = PROD_W'(dividend) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= product[SHIFT +: SAMPLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/kir_store.sv -----
module kir_store #(
    parameter int  MAX_INTERVALS = kir_pkg::MAX_INTERVALS_DEFAULT,
    localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  logic                            clk,
    input  kir_pkg::store_ctl_t             ctl,
    input  logic [IDX_W-1:0]                wr_addr,
    input  logic [kir_pkg::INTERVAL_W-1:0]  wr_data,
    input  logic [IDX_W-1:0]                rd_addr,
    output logic [kir_pkg::INTERVAL_W-1:0]  rd_data
);
    import kir_pkg::*;

    logic [INTERVAL_W-1:0] mem [MAX_INTERVALS];
    logic [INTERVAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
